### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPHC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tphc_pkg.sv
// ----------------------------------------------------------------------------
// tphc_pkg
// Shared types, constants and helpers of the sensor compensation core.
// ----------------------------------------------------------------------------
package tphc_pkg;

    localparam logic [23:0] TEMP_SKIP_WORD = 24'h800000;
    localparam logic [15:0] HUM_OFF_WORD   = 16'h8000;
    localparam logic [31:0] HUM_CLAMP      = 32'd419430400;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_SKIP = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_HUM_OFF  = 2'd3;

    localparam logic [2:0] REG_CAL_TEMP  = 3'd0;
    localparam logic [2:0] REG_PRESS_LO  = 3'd1;
    localparam logic [2:0] REG_PRESS_HI  = 3'd2;
    localparam logic [2:0] REG_MIXED     = 3'd3;
    localparam logic [2:0] REG_HUM_H45   = 3'd4;

    // One raw sample with its classification flags
    typedef struct packed {
        logic [23:0] raw_temp;
        logic [23:0] raw_press;
        logic [15:0] raw_hum;
        logic        skip;
        logic        hum_off;
    } item_t;

    // Calibration words as held in the register file
    typedef struct packed {
        logic [47:0] cal_temp;
        logic [63:0] cal_press_low;
        logic [63:0] cal_press_high;
        logic [55:0] cal_mixed;
        logic [23:0] cal_hum_h45;
    } cal_t;

    typedef enum logic [5:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_TF,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
        S_DIVS, S_DIV, S_DIVE,
        S_P7, S_P8, S_P9, S_PF,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7,
        S_DONE
    } state_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned sh);
        return 64'($signed(v) >>> sh);
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned sh);
        return 32'($signed(v) >>> sh);
    endfunction

endpackage

### rtl/core/tphc_front.sv
// ----------------------------------------------------------------------------
// tphc_front
// Input register stage: accepts raw samples and flags the special words.
// ----------------------------------------------------------------------------
module tphc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [23:0]          s_raw_temp,
    input  logic [23:0]          s_raw_press,
    input  logic [15:0]          s_raw_hum,
    output logic                 f_valid,
    output tphc_pkg::item_t      f_item,
    input  logic                 f_ready
);

    logic            valid_reg;
    logic            valid_next;
    tphc_pkg::item_t item_reg;
    tphc_pkg::item_t item_next;

    // Take a new item whenever the stage is empty or drains this cycle
    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    // Classify the incoming item
    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
        if (s_valid && s_ready) begin
            item_next.raw_temp  = s_raw_temp;
            item_next.raw_press = s_raw_press;
            item_next.raw_hum   = s_raw_hum;
            item_next.skip      = (s_raw_temp == tphc_pkg::TEMP_SKIP_WORD);
            item_next.hum_off   = (s_raw_hum == tphc_pkg::HUM_OFF_WORD);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

### rtl/core/tphc_queue.sv
// ----------------------------------------------------------------------------
// tphc_queue
// Two-entry item queue between the front stage and the compute engine.
// ----------------------------------------------------------------------------
module tphc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  tphc_pkg::item_t  push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output tphc_pkg::item_t  pop_item
);

    tphc_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/tphc_back.sv
// ----------------------------------------------------------------------------
// tphc_back
// Compute engine: one shared 32x32 multiplier, a radix-2 divider and an
// output register holding the finished result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tphc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tphc_pkg::cal_t      cal,
    input  logic                q_valid,
    output logic                q_ready,
    input  tphc_pkg::item_t     q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [23:0]  m_temp_centideg,
    output logic signed [31:0]  m_pressure_pa,
    output logic [16:0]         m_humidity_q10,
    output logic [1:0]          m_status
);

    tphc_pkg::state_t state_reg, state_next;

    // Item and working registers
    tphc_pkg::item_t item_reg, item_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  mph_reg, mph_next;
    logic [63:0] tf_reg, tf_next;
    logic [63:0] v1_reg, v1_next;
    logic [63:0] v2_reg, v2_next;
    logic [63:0] w_reg, w_next;
    logic [63:0] vv_reg, vv_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dmag_reg, dmag_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] ha_reg, ha_next;
    logic [31:0] ta_reg, ta_next;
    logic [31:0] tb_reg, tb_next;
    logic [31:0] hb_reg, hb_next;
    logic [31:0] xx_reg, xx_next;
    logic [23:0] temp_w_reg, temp_w_next;
    logic [31:0] press_w_reg, press_w_next;
    logic [16:0] hum_w_reg, hum_w_next;
    logic [1:0]  stat_w_reg, stat_w_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_temp_reg, out_temp_next;
    logic [31:0] out_press_reg, out_press_next;
    logic [16:0] out_hum_reg, out_hum_next;
    logic [1:0]  out_stat_reg, out_stat_next;

    // Calibration fields
    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]  h1, h3, h6;
    logic [11:0] h4, h5;

    assign t1 = cal.cal_temp[15:0];
    assign t2 = cal.cal_temp[31:16];
    assign t3 = cal.cal_temp[47:32];
    assign p1 = cal.cal_press_low[15:0];
    assign p2 = cal.cal_press_low[31:16];
    assign p3 = cal.cal_press_low[47:32];
    assign p4 = cal.cal_press_low[63:48];
    assign p5 = cal.cal_press_high[15:0];
    assign p6 = cal.cal_press_high[31:16];
    assign p7 = cal.cal_press_high[47:32];
    assign p8 = cal.cal_press_high[63:48];
    assign p9 = cal.cal_mixed[15:0];
    assign h1 = cal.cal_mixed[23:16];
    assign h2 = cal.cal_mixed[39:24];
    assign h3 = cal.cal_mixed[47:40];
    assign h6 = cal.cal_mixed[55:48];
    assign h4 = cal.cal_hum_h45[11:0];
    assign h5 = cal.cal_hum_h45[23:12];

    // Derived operands
    logic [19:0] adc;
    logic [63:0] ta_op, tb_op, pv, x64, pnum, psh;
    logic [31:0] x32, acc32, hx15;
    logic        is_mul, mul_done, out_free;

    assign adc   = item_reg.raw_temp[23:4];
    assign ta_op = 64'(adc[19:3]) - 64'({t1, 1'b0});
    assign tb_op = 64'(adc[19:4]) - 64'(t1);
    assign pv    = tf_reg - 64'd128000;
    assign x32   = tf_reg[31:0] - 32'd76800;
    assign x64   = tphc_pkg::sx32(x32);
    assign pnum  = ((64'd1048576 - 64'(item_reg.raw_press[23:4])) << 31) - v2_reg;
    assign psh   = tphc_pkg::asr64(num_reg, 13);
    assign hx15  = tphc_pkg::asr32(xx_reg, 15);
    assign acc32 = acc_reg[31:0];
    assign out_free = !out_valid_reg || m_ready;

    // Operand select of the shared multiplier
    logic [63:0] op_a, op_b;
    always_comb begin
        is_mul = 1'b1;
        op_a   = 64'd0;
        op_b   = 64'd0;
        case (state_reg)
            tphc_pkg::S_T0: begin op_a = ta_op; op_b = tphc_pkg::sx16(t2); end
            tphc_pkg::S_T1: begin op_a = tb_op; op_b = tb_op; end
            tphc_pkg::S_T2: begin op_a = w_reg; op_b = tphc_pkg::sx16(t3); end
            tphc_pkg::S_P0: begin op_a = pv; op_b = pv; end
            tphc_pkg::S_P1: begin op_a = vv_reg; op_b = tphc_pkg::sx16(p6); end
            tphc_pkg::S_P2: begin op_a = pv; op_b = tphc_pkg::sx16(p5); end
            tphc_pkg::S_P3: begin op_a = vv_reg; op_b = tphc_pkg::sx16(p3); end
            tphc_pkg::S_P4: begin op_a = pv; op_b = tphc_pkg::sx16(p2); end
            tphc_pkg::S_P5: begin op_a = (64'd1 << 47) + w_reg; op_b = 64'(p1); end
            tphc_pkg::S_P6: begin op_a = pnum; op_b = 64'd3125; end
            tphc_pkg::S_P7: begin op_a = tphc_pkg::sx16(p9); op_b = psh; end
            tphc_pkg::S_P8: begin op_a = w_reg; op_b = psh; end
            tphc_pkg::S_P9: begin op_a = tphc_pkg::sx16(p8); op_b = num_reg; end
            tphc_pkg::S_H0: begin op_a = x64; op_b = 64'(h5); end
            tphc_pkg::S_H1: begin op_a = x64; op_b = tphc_pkg::sx8(h6); end
            tphc_pkg::S_H2: begin op_a = x64; op_b = 64'(h3); end
            tphc_pkg::S_H3: begin
                op_a = tphc_pkg::sx32(ta_reg);
                op_b = tphc_pkg::sx32(tb_reg);
            end
            tphc_pkg::S_H4: begin op_a = tphc_pkg::sx32(hb_reg); op_b = tphc_pkg::sx16(h2); end
            tphc_pkg::S_H5: begin
                op_a = tphc_pkg::sx32(ha_reg);
                op_b = tphc_pkg::sx32(hb_reg);
            end
            tphc_pkg::S_H6: begin op_a = tphc_pkg::sx32(hx15); op_b = tphc_pkg::sx32(hx15); end
            tphc_pkg::S_H7: begin op_a = tphc_pkg::sx32(ta_reg); op_b = 64'(h1); end
            default: is_mul = 1'b0;
        endcase
    end

    // 64x64 low product in four passes over one 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_a    = (mph_reg == 2'd2) ? op_a[63:32] : op_a[31:0];
    assign mul_b    = (mph_reg == 2'd1) ? op_b[63:32] : op_b[31:0];
    assign mul_p    = 64'(mul_a) * 64'(mul_b);
    assign mul_done = is_mul && (mph_reg == 2'd3);

    // Divider step
    logic [64:0] div_sh, div_diff;
    assign div_sh   = {rem_reg, quo_reg[63]};
    assign div_diff = div_sh - {1'b0, dmag_reg};

    // Pressure finish and humidity finish values
    logic [63:0] pf;
    logic [31:0] pl, hx;
    logic [63:0] den_new;
    assign pf  = tphc_pkg::asr64(num_reg + v1_reg + v2_reg, 8) + (tphc_pkg::sx16(p7) << 4);
    assign pl  = pf[31:0];
    assign hx  = xx_reg - tphc_pkg::asr32(tphc_pkg::asr32(acc32, 0), 4);
    assign den_new = tphc_pkg::asr64(acc_reg, 33);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tphc_pkg::S_IDLE: begin
                if (q_valid) begin
                    state_next = q_item.skip ? tphc_pkg::S_DONE : tphc_pkg::S_T0;
                end
            end
            tphc_pkg::S_T0: if (mul_done) state_next = tphc_pkg::S_T1;
            tphc_pkg::S_T1: if (mul_done) state_next = tphc_pkg::S_T2;
            tphc_pkg::S_T2: if (mul_done) state_next = tphc_pkg::S_TF;
            tphc_pkg::S_TF: state_next = tphc_pkg::S_P0;
            tphc_pkg::S_P0: if (mul_done) state_next = tphc_pkg::S_P1;
            tphc_pkg::S_P1: if (mul_done) state_next = tphc_pkg::S_P2;
            tphc_pkg::S_P2: if (mul_done) state_next = tphc_pkg::S_P3;
            tphc_pkg::S_P3: if (mul_done) state_next = tphc_pkg::S_P4;
            tphc_pkg::S_P4: if (mul_done) state_next = tphc_pkg::S_P5;
            tphc_pkg::S_P5: begin
                if (mul_done) begin
                    state_next = (den_new == 64'd0) ? tphc_pkg::S_DONE : tphc_pkg::S_P6;
                end
            end
            tphc_pkg::S_P6: if (mul_done) state_next = tphc_pkg::S_DIVS;
            tphc_pkg::S_DIVS: state_next = tphc_pkg::S_DIV;
            tphc_pkg::S_DIV: if (cnt_reg == 6'd63) state_next = tphc_pkg::S_DIVE;
            tphc_pkg::S_DIVE: state_next = tphc_pkg::S_P7;
            tphc_pkg::S_P7: if (mul_done) state_next = tphc_pkg::S_P8;
            tphc_pkg::S_P8: if (mul_done) state_next = tphc_pkg::S_P9;
            tphc_pkg::S_P9: if (mul_done) state_next = tphc_pkg::S_PF;
            tphc_pkg::S_PF: begin
                state_next = item_reg.hum_off ? tphc_pkg::S_DONE : tphc_pkg::S_H0;
            end
            tphc_pkg::S_H0: if (mul_done) state_next = tphc_pkg::S_H1;
            tphc_pkg::S_H1: if (mul_done) state_next = tphc_pkg::S_H2;
            tphc_pkg::S_H2: if (mul_done) state_next = tphc_pkg::S_H3;
            tphc_pkg::S_H3: if (mul_done) state_next = tphc_pkg::S_H4;
            tphc_pkg::S_H4: if (mul_done) state_next = tphc_pkg::S_H5;
            tphc_pkg::S_H5: if (mul_done) state_next = tphc_pkg::S_H6;
            tphc_pkg::S_H6: if (mul_done) state_next = tphc_pkg::S_H7;
            tphc_pkg::S_H7: if (mul_done) state_next = tphc_pkg::S_DONE;
            tphc_pkg::S_DONE: if (out_free) state_next = tphc_pkg::S_IDLE;
            default: state_next = tphc_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        q_ready        = 1'b0;
        item_next      = item_reg;
        acc_next       = acc_reg;
        mph_next       = mph_reg;
        tf_next        = tf_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        w_next         = w_reg;
        vv_next        = vv_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        ha_next        = ha_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        hb_next        = hb_reg;
        xx_next        = xx_reg;
        temp_w_next    = temp_w_reg;
        press_w_next   = press_w_reg;
        hum_w_next     = hum_w_reg;
        stat_w_next    = stat_w_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_temp_next  = out_temp_reg;
        out_press_next = out_press_reg;
        out_hum_next   = out_hum_reg;
        out_stat_next  = out_stat_reg;

        // Multiplier passes
        if (is_mul) begin
            mph_next = mph_reg + 2'd1;
            unique case (mph_reg)
                2'd0: acc_next = mul_p;
                2'd1, 2'd2: acc_next = acc_reg + {mul_p[31:0], 32'd0};
                default: acc_next = acc_reg;
            endcase
        end

        unique case (state_reg)
            tphc_pkg::S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next    = q_item;
                    temp_w_next  = 24'd0;
                    press_w_next = 32'd0;
                    hum_w_next   = 17'd0;
                    stat_w_next  = q_item.skip ? tphc_pkg::ST_TEMP_SKIP : tphc_pkg::ST_OK;
                end
            end
            tphc_pkg::S_T0: if (mul_done) v1_next = tphc_pkg::asr64(acc_reg, 11);
            tphc_pkg::S_T1: if (mul_done) w_next = tphc_pkg::asr64(acc_reg, 12);
            tphc_pkg::S_T2: if (mul_done) tf_next = v1_reg + tphc_pkg::asr64(acc_reg, 14);
            tphc_pkg::S_TF: begin
                temp_w_next = 24'(tphc_pkg::asr64((tf_reg << 2) + tf_reg + 64'd128, 8));
            end
            tphc_pkg::S_P0: if (mul_done) vv_next = acc_reg;
            tphc_pkg::S_P1: if (mul_done) v2_next = acc_reg;
            tphc_pkg::S_P2: begin
                if (mul_done) begin
                    v2_next = v2_reg + (acc_reg << 17) + (tphc_pkg::sx16(p4) << 35);
                end
            end
            tphc_pkg::S_P3: if (mul_done) w_next = tphc_pkg::asr64(acc_reg, 8);
            tphc_pkg::S_P4: if (mul_done) w_next = w_reg + (acc_reg << 12);
            tphc_pkg::S_P5: begin
                if (mul_done) begin
                    den_next = den_new;
                    if (den_new == 64'd0) begin
                        stat_w_next = tphc_pkg::ST_DIV_ZERO;
                    end
                end
            end
            tphc_pkg::S_P6: if (mul_done) num_next = acc_reg;
            tphc_pkg::S_DIVS: begin
                rem_next  = 64'd0;
                quo_next  = num_reg[63] ? 64'd0 - num_reg : num_reg;
                dmag_next = den_reg[63] ? 64'd0 - den_reg : den_reg;
                neg_next  = num_reg[63] ^ den_reg[63];
                cnt_next  = 6'd0;
            end
            tphc_pkg::S_DIV: begin
                cnt_next = cnt_reg + 6'd1;
                if (!div_diff[64]) begin
                    rem_next = div_diff[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = div_sh[63:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            tphc_pkg::S_DIVE: num_next = neg_reg ? 64'd0 - quo_reg : quo_reg;
            tphc_pkg::S_P7: if (mul_done) w_next = acc_reg;
            tphc_pkg::S_P8: if (mul_done) v1_next = tphc_pkg::asr64(acc_reg, 25);
            tphc_pkg::S_P9: if (mul_done) v2_next = tphc_pkg::asr64(acc_reg, 19);
            tphc_pkg::S_PF: begin
                // Truncate toward zero on the divide by 256
                press_w_next = tphc_pkg::asr32(pl + (pl[31] ? 32'd255 : 32'd0), 8);
                if (item_reg.hum_off) begin
                    stat_w_next = tphc_pkg::ST_HUM_OFF;
                end
            end
            tphc_pkg::S_H0: begin
                if (mul_done) begin
                    ha_next = tphc_pkg::asr32({2'b00, item_reg.raw_hum, 14'd0}
                                              - {h4, 20'd0} - acc32 + 32'd16384, 15);
                end
            end
            tphc_pkg::S_H1: if (mul_done) ta_next = tphc_pkg::asr32(acc32, 10);
            tphc_pkg::S_H2: if (mul_done) tb_next = tphc_pkg::asr32(acc32, 11) + 32'd32768;
            tphc_pkg::S_H3: if (mul_done) hb_next = tphc_pkg::asr32(acc32, 10) + 32'd2097152;
            tphc_pkg::S_H4: if (mul_done) hb_next = tphc_pkg::asr32(acc32 + 32'd8192, 14);
            tphc_pkg::S_H5: if (mul_done) xx_next = acc32;
            tphc_pkg::S_H6: if (mul_done) ta_next = tphc_pkg::asr32(acc32, 7);
            tphc_pkg::S_H7: begin
                // Clamp to 0..100 %RH before dropping the fraction
                if (mul_done) begin
                    if (hx[31]) begin
                        hum_w_next = 17'd0;
                    end else if (hx > tphc_pkg::HUM_CLAMP) begin
                        hum_w_next = tphc_pkg::HUM_CLAMP[28:12];
                    end else begin
                        hum_w_next = hx[28:12];
                    end
                end
            end
            tphc_pkg::S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_temp_next  = temp_w_reg;
                    out_press_next = press_w_reg;
                    out_hum_next   = hum_w_reg;
                    out_stat_next  = stat_w_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tphc_pkg::S_IDLE;
            mph_reg       <= 2'd0;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mph_reg       <= mph_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg      <= item_next;
        acc_reg       <= acc_next;
        tf_reg        <= tf_next;
        v1_reg        <= v1_next;
        v2_reg        <= v2_next;
        w_reg         <= w_next;
        vv_reg        <= vv_next;
        den_reg       <= den_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dmag_reg      <= dmag_next;
        neg_reg       <= neg_next;
        ha_reg        <= ha_next;
        ta_reg        <= ta_next;
        tb_reg        <= tb_next;
        hb_reg        <= hb_next;
        xx_reg        <= xx_next;
        temp_w_reg    <= temp_w_next;
        press_w_reg   <= press_w_next;
        hum_w_reg     <= hum_w_next;
        stat_w_reg    <= stat_w_next;
        out_temp_reg  <= out_temp_next;
        out_press_reg <= out_press_next;
        out_hum_reg   <= out_hum_next;
        out_stat_reg  <= out_stat_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_temp_centideg = $signed(out_temp_reg);
    assign m_pressure_pa   = $signed(out_press_reg);
    assign m_humidity_q10  = out_hum_reg;
    assign m_status        = out_stat_reg;

    `TPHC_ASSERT_IMPL(a_hum_range, aclk, aresetn, out_valid_reg, out_hum_reg <= 17'd102400, "humidity above clamp")
    `TPHC_ASSERT_IMPL(a_skip_zero, aclk, aresetn, out_valid_reg && (out_stat_reg == tphc_pkg::ST_TEMP_SKIP), (out_temp_reg == 24'd0) && (out_press_reg == 32'd0) && (out_hum_reg == 17'd0), "skipped sample with nonzero fields")
    `TPHC_ASSERT_NEXT(a_done_loads, aclk, aresetn, (state_reg == tphc_pkg::S_DONE) && out_free, out_valid_reg, "finished item not presented")
    `TPHC_ASSERT_IMPL(a_mph_idle, aclk, aresetn, !is_mul, mph_reg == 2'd0, "multiplier pass count left running")

endmodule

### rtl/core/temp_press_hum_compensation_top.sv
// Each full item runs 21 four-pass multiplies on the shared 32x32 multiplier
// and a 64-step divider; the engine takes the next item only when done.
// A skipped sample, a zero pressure divisor or disabled humidity cuts the
// computation short.
// The front stage and a two-entry queue accept items while the engine works.
// Reset: synchronous active-low aresetn clears control state and calibration.
// ----------------------------------------------------------------------------
// temp_press_hum_compensation_top
// Integer compensation of temperature, pressure and humidity samples with
// calibration words written over an APB-style port.
// ----------------------------------------------------------------------------
module temp_press_hum_compensation_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [23:0]         s_raw_temp,
    input  logic [23:0]         s_raw_press,
    input  logic [15:0]         s_raw_hum,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [23:0]  m_temp_centideg,
    output logic signed [31:0]  m_pressure_pa,
    output logic [16:0]         m_humidity_q10,
    output logic [1:0]          m_status
);

    tphc_pkg::cal_t  cal_reg, cal_next;
    logic [2:0]      reg_idx;
    logic            wr_en;
    logic            f_valid, f_ready;
    tphc_pkg::item_t f_item;
    logic            q_valid, q_ready;
    tphc_pkg::item_t q_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    // Write calibration registers
    always_comb begin
        cal_next = cal_reg;
        if (wr_en) begin
            unique case (reg_idx)
                tphc_pkg::REG_CAL_TEMP: cal_next.cal_temp       = pwdata[47:0];
                tphc_pkg::REG_PRESS_LO: cal_next.cal_press_low  = pwdata;
                tphc_pkg::REG_PRESS_HI: cal_next.cal_press_high = pwdata;
                tphc_pkg::REG_MIXED:    cal_next.cal_mixed      = pwdata[55:0];
                tphc_pkg::REG_HUM_H45:  cal_next.cal_hum_h45    = pwdata[23:0];
                default: cal_next = cal_reg;
            endcase
        end
    end

    // Read back calibration registers
    always_comb begin
        unique case (reg_idx)
            tphc_pkg::REG_CAL_TEMP: prdata = 64'(cal_reg.cal_temp);
            tphc_pkg::REG_PRESS_LO: prdata = cal_reg.cal_press_low;
            tphc_pkg::REG_PRESS_HI: prdata = cal_reg.cal_press_high;
            tphc_pkg::REG_MIXED:    prdata = 64'(cal_reg.cal_mixed);
            tphc_pkg::REG_HUM_H45:  prdata = 64'(cal_reg.cal_hum_h45);
            default: prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    tphc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_raw_temp  (s_raw_temp),
        .s_raw_press (s_raw_press),
        .s_raw_hum   (s_raw_hum),
        .f_valid     (f_valid),
        .f_item      (f_item),
        .f_ready     (f_ready)
    );

    tphc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    tphc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cal             (cal_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_temp_centideg (m_temp_centideg),
        .m_pressure_pa   (m_pressure_pa),
        .m_humidity_q10  (m_humidity_q10),
        .m_status        (m_status)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw sensor samples through temp_press_hum_compensation_top under
// several calibration sets and compares every compensated reading with an
// in-bench integer model, with random idling on the sample and result sides.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [23:0] raw_temp;
        logic [23:0] raw_press;
        logic [15:0] raw_hum;
        logic        wait_drain;
    } raw_sample_t;

    typedef struct {
        logic [23:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
        logic [1:0]  status;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_raw_temp;
    logic [23:0] s_raw_press;
    logic [15:0] s_raw_hum;
    logic        m_valid;
    logic        m_ready;
    logic signed [23:0] m_temp_centideg;
    logic signed [31:0] m_pressure_pa;
    logic [16:0] m_humidity_q10;
    logic [1:0]  m_status;

    // Calibration copy used by the predictor
    logic [47:0] cal_temp_q;
    logic [63:0] cal_plo_q;
    logic [63:0] cal_phi_q;
    logic [55:0] cal_mixed_q;
    logic [23:0] cal_h45_q;

    raw_sample_t samples_to_send[$];
    reading_t    readings_due[$];
    int          error_count;
    int          send_gap;
    int          ready_stall;
    bit          no_idling;

    temp_press_hum_compensation_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_temp      (s_raw_temp),
        .s_raw_press     (s_raw_press),
        .s_raw_hum       (s_raw_hum),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_temp_centideg (m_temp_centideg),
        .m_pressure_pa   (m_pressure_pa),
        .m_humidity_q10  (m_humidity_q10),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Compensate one sample with the current calibration
    function automatic reading_t compensate(input raw_sample_t s);
        reading_t r;
        logic [63:0] adc, a, b, v1, v2, tf, p, num, ma, mb, q, pv, s1;
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, u, w, y, z, pl;
        r = '{24'd0, 32'd0, 17'd0, tphc_pkg::ST_OK};
        if (s.raw_temp == tphc_pkg::TEMP_SKIP_WORD) begin
            r.status = tphc_pkg::ST_TEMP_SKIP;
            return r;
        end
        t1 = {48'd0, cal_temp_q[15:0]};
        t2 = {{48{cal_temp_q[31]}}, cal_temp_q[31:16]};
        t3 = {{48{cal_temp_q[47]}}, cal_temp_q[47:32]};
        adc = {44'd0, s.raw_temp[23:4]};
        a = (adc >> 3) - (t1 << 1);
        v1 = $signed(a * t2) >>> 11;
        b = (adc >> 4) - t1;
        v2 = $signed(b * b) >>> 12;
        v2 = $signed(v2 * t3) >>> 14;
        tf = v1 + v2;
        v1 = $signed(tf * 64'd5 + 64'd128) >>> 8;
        r.temp = v1[23:0];

        p1 = {48'd0, cal_plo_q[15:0]};
        p2 = {{48{cal_plo_q[31]}}, cal_plo_q[31:16]};
        p3 = {{48{cal_plo_q[47]}}, cal_plo_q[47:32]};
        p4 = {{48{cal_plo_q[63]}}, cal_plo_q[63:48]};
        p5 = {{48{cal_phi_q[15]}}, cal_phi_q[15:0]};
        p6 = {{48{cal_phi_q[31]}}, cal_phi_q[31:16]};
        p7 = {{48{cal_phi_q[47]}}, cal_phi_q[47:32]};
        p8 = {{48{cal_phi_q[63]}}, cal_phi_q[63:48]};
        p9 = {{48{cal_mixed_q[15]}}, cal_mixed_q[15:0]};

        v1 = tf - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        // Keep each arithmetic shift in a statement of its own
        s1 = $signed(v1 * v1 * p3) >>> 8;
        v1 = s1 + ((v1 * p2) << 12);
        v1 = $signed(((64'd1 << 47) + v1) * p1) >>> 33;
        if (v1 == 64'd0) begin
            r.status = tphc_pkg::ST_DIV_ZERO;
            return r;
        end
        p = 64'd1048576 - {44'd0, s.raw_press[23:4]};
        num = ((p << 31) - v2) * 64'd3125;
        // Signed division, truncating toward zero
        ma = num[63] ? -num : num;
        mb = v1[63] ? -v1 : v1;
        q = ma / mb;
        p = (num[63] ^ v1[63]) ? -q : q;
        pv = $signed(p) >>> 13;
        v1 = $signed(p9 * pv * pv) >>> 25;
        v2 = $signed(p8 * p) >>> 19;
        s1 = $signed(p + v1 + v2) >>> 8;
        p = s1 + (p7 << 4);
        pl = p[31:0];
        pl = pl[31] ? -((-pl) / 32'd256) : pl / 32'd256;
        r.press = pl;

        if (s.raw_hum == tphc_pkg::HUM_OFF_WORD) begin
            r.status = tphc_pkg::ST_HUM_OFF;
            return r;
        end
        h1 = {24'd0, cal_mixed_q[23:16]};
        h2 = {{16{cal_mixed_q[39]}}, cal_mixed_q[39:24]};
        h3 = {24'd0, cal_mixed_q[47:40]};
        h6 = {{24{cal_mixed_q[55]}}, cal_mixed_q[55:48]};
        h4 = {20'd0, cal_h45_q[11:0]};
        h5 = {20'd0, cal_h45_q[23:12]};
        x = tf[31:0] - 32'd76800;
        ha = $signed(({16'd0, s.raw_hum} << 14) - (h4 << 20) - h5 * x + 32'd16384) >>> 15;
        u = $signed(x * h6) >>> 10;
        w = $signed(x * h3) >>> 11;
        w = w + 32'd32768;
        hb = $signed(u * w) >>> 10;
        hb = hb + 32'd2097152;
        hb = $signed(hb * h2 + 32'd8192) >>> 14;
        x = ha * hb;
        y = $signed(x) >>> 15;
        z = $signed(y * y) >>> 7;
        z = $signed(z * h1) >>> 4;
        x = x - z;
        if (x[31])
            x = 32'd0;
        if (x > tphc_pkg::HUM_CLAMP)
            x = tphc_pkg::HUM_CLAMP;
        r.hum = x[28:12];
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idling || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 200);
    endfunction

    // Sample driver: hold until accepted, then idle or present the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid && s_ready)
                readings_due.push_back(compensate('{s_raw_temp, s_raw_press, s_raw_hum, 1'b0}));
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (samples_to_send.size() > 0 &&
                         (!samples_to_send[0].wait_drain || readings_due.size() == 0)) begin
                raw_sample_t nxt;
                nxt = samples_to_send.pop_front();
                s_raw_temp <= nxt.raw_temp;
                s_raw_press <= nxt.raw_press;
                s_raw_hum <= nxt.raw_hum;
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, check each reading against the oldest due
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: unexpected reading temp=%0d press=%0d hum=%0d st=%0d",
                             $time, m_temp_centideg, m_pressure_pa, m_humidity_q10, m_status);
                    error_count++;
                end else begin
                    reading_t e;
                    e = readings_due.pop_front();
                    if (m_temp_centideg !== e.temp || m_pressure_pa !== e.press ||
                        m_humidity_q10 !== e.hum || m_status !== e.status) begin
                        $display("%0t: mismatch exp temp=%0d press=%0d hum=%0d st=%0d",
                                 $time, $signed(e.temp), $signed(e.press), e.hum, e.status);
                        $display("%0t:          act temp=%0d press=%0d hum=%0d st=%0d",
                                 $time, m_temp_centideg, m_pressure_pa, m_humidity_q10,
                                 m_status);
                        error_count++;
                    end
                end
            end
            if (ready_stall > 0) begin
                m_ready <= 1'b0;
                ready_stall <= ready_stall - 1;
            end else begin
                m_ready <= 1'b1;
                ready_stall <= pick_gap();
            end
        end
    end

    // Write one calibration register over the APB port
    task automatic write_cal(input logic [2:0] idx, input logic [63:0] value);
        case (idx)
            tphc_pkg::REG_CAL_TEMP: cal_temp_q = value[47:0];
            tphc_pkg::REG_PRESS_LO: cal_plo_q = value;
            tphc_pkg::REG_PRESS_HI: cal_phi_q = value;
            tphc_pkg::REG_MIXED:    cal_mixed_q = value[55:0];
            tphc_pkg::REG_HUM_H45:  cal_h45_q = value[23:0];
            default: ;
        endcase
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] ct, input logic [63:0] plo,
                            input logic [63:0] phi, input logic [55:0] mx,
                            input logic [23:0] h45);
        write_cal(tphc_pkg::REG_CAL_TEMP, {16'd0, ct});
        write_cal(tphc_pkg::REG_PRESS_LO, plo);
        write_cal(tphc_pkg::REG_PRESS_HI, phi);
        write_cal(tphc_pkg::REG_MIXED, {8'd0, mx});
        write_cal(tphc_pkg::REG_HUM_H45, {40'd0, h45});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Typical calibration, optionally jittered
    task automatic load_typical(input bit jitter);
        logic [63:0] plo, phi;
        logic [47:0] ct;
        logic [55:0] mx;
        ct = {16'hFC18, 16'd26435, 16'd27504};
        plo = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
        phi = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        mx = {8'd30, 8'd0, 16'd362, 8'd75, 16'd6000};
        if (jitter) begin
            ct = ct ^ {8'($urandom_range(0, 255)), 8'd0, 8'($urandom_range(0, 255)), 8'd0,
                       16'($urandom_range(0, 4095))};
            plo = plo ^ {48'($urandom_range(0, 63)), 16'($urandom_range(0, 8191))};
            phi = phi ^ {64'($urandom_range(0, 1023))};
            mx = mx ^ {8'($urandom_range(0, 15)), 8'($urandom()), 16'($urandom_range(0, 511)),
                       8'($urandom()), 16'($urandom_range(0, 2047))};
        end
        load_cal(ct, plo, phi, mx, jitter ? 24'($urandom()) : {12'd50, 12'd324});
    endtask

    function automatic raw_sample_t random_sample();
        raw_sample_t s;
        int mode;
        mode = $urandom_range(0, 99);
        s.raw_temp = 24'($urandom());
        s.raw_press = 24'($urandom());
        s.raw_hum = 16'($urandom());
        if (mode < 55) begin
            s.raw_temp = {20'($urandom_range(380000, 640000)), 4'($urandom())};
            s.raw_press = {20'($urandom_range(200000, 500000)), 4'($urandom())};
            s.raw_hum = 16'($urandom_range(15000, 45000));
        end else if (mode < 62) begin
            s.raw_temp = tphc_pkg::TEMP_SKIP_WORD;
        end else if (mode < 69) begin
            s.raw_hum = tphc_pkg::HUM_OFF_WORD;
        end
        s.wait_drain = ($urandom_range(0, 99) < 2);
        return s;
    endfunction

    task automatic add_sample(input logic [23:0] t, input logic [23:0] p,
                              input logic [15:0] h);
        samples_to_send.push_back('{t, p, h, 1'b0});
    endtask

    // Let every queued item go through and every reading come back
    task automatic drain();
        while (samples_to_send.size() > 0 || s_valid || readings_due.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_raw_temp = '0;
        s_raw_press = '0;
        s_raw_hum = '0;
        m_ready = 1'b0;
        error_count = 0;
        send_gap = 0;
        ready_stall = 0;
        no_idling = 1'b0;
        cal_temp_q = '0;
        cal_plo_q = '0;
        cal_phi_q = '0;
        cal_mixed_q = '0;
        cal_h45_q = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset calibration: zero divisor, plus a skipped sample
        add_sample(24'h7EED00, 24'h655A00, 16'h6A00);
        add_sample(tphc_pkg::TEMP_SKIP_WORD, 24'hFFFFFF, 16'hFFFF);
        add_sample(24'h000000, 24'h000000, tphc_pkg::HUM_OFF_WORD);
        drain();

        // Typical calibration with field extremes and special words
        load_typical(1'b0);
        add_sample(24'h7EED00, 24'h655A00, 16'h6A00);
        add_sample(24'h000000, 24'h000000, 16'h0000);
        add_sample(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        add_sample(24'h7FFFFF, 24'h800000, 16'h7FFF);
        add_sample(24'h800001, 24'h7FFFFF, 16'h8001);
        add_sample(tphc_pkg::TEMP_SKIP_WORD, 24'h655A00, 16'h6A00);
        add_sample(24'h7EED00, 24'h655A00, tphc_pkg::HUM_OFF_WORD);
        add_sample(24'h80000F, 24'h00000F, 16'h000F);
        add_sample(24'h5A5A5A, 24'hA5A5A5, 16'h5A5A);
        add_sample(24'hA5A5A5, 24'h5A5A5A, 16'hA5A5);
        add_sample(24'h600000, 24'h400000, 16'hC000);
        add_sample(24'h900000, 24'h300000, 16'h2000);
        samples_to_send.push_back('{24'h7EED00, 24'h655A00, 16'h6A00, 1'b1});
        drain();

        // All-ones and all-zero calibration
        load_cal('1, '1, '1, '1, '1);
        repeat (40) samples_to_send.push_back(random_sample());
        drain();
        load_cal('0, '0, '0, '0, '0);
        repeat (20) samples_to_send.push_back(random_sample());
        drain();

        // Random phases: mostly near-typical calibration, some fully random
        for (int ph = 0; ph < 9; ph++) begin
            no_idling = (ph == 3);
            if (ph % 3 == 2)
                load_cal(48'(rand64()), rand64(), rand64(), 56'(rand64()), 24'($urandom()));
            else
                load_typical(1'b1);
            repeat (100) samples_to_send.push_back(random_sample());
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
